[rtl/core/c8cpu_pkg.sv]
// Shared constants, codes and types for the CHIP-8 processor core.
// No dependencies; used by chip8_cpu_core_top and c8cpu_alu in rtl/core.
package c8cpu_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PIX_AW        = $clog2(PIXEL_COUNT);
    localparam int PX_W          = $clog2(SCREEN_WIDTH);
    localparam int PY_W          = $clog2(SCREEN_HEIGHT);
    localparam int NUM_V         = 16;
    localparam int V_AW          = $clog2(NUM_V);
    localparam int FONT_BYTES    = 80;

    localparam logic [15:0] PC_START = 16'h0200;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_PIXEL = 3'd2;
    localparam logic [2:0] CMD_EXEC  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN = 2'd1;
    localparam logic [1:0] STAT_WAITKEY = 2'd2;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [7:0] result;
        logic       flag;
        logic       vf_we;
        logic       legal;
    } alu_res_t;

endpackage

[rtl/core/chip8_cpu_core_top.sv]
// CHIP-8 processor core: sequencer, register file, memory and framebuffer.
// Depends on c8cpu_pkg, c8cpu_ram and c8cpu_alu.
//
// One command item is taken at a time; in_stall stays high until its result
// is moved into the output register, which waits while out_stall holds the
// previous result. After reset a clearing pass loads the font
// and zeroes memory, framebuffer and V0-VF before the first item is taken.
// Memory write, timer tick and unused commands go straight to the result
// state; memory and pixel reads pass a read state. An instruction fetches
// the opcode and VX, VY, V0 through single-port RAMs, then executes: 8XYn
// writing VF adds a VF write, FX33 writes three digits, FX55/FX65 move V0-VX
// one at a time, 00E0 clears each pixel, DXYN read-modify-writes lit pixels.
module chip8_cpu_core_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [11:0] address,
    input  logic [7:0]  data,
    input  logic [15:0] key_now,
    input  logic [15:0] key_before,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [15:0] program_counter,
    output logic        screen_changed,
    output logic        sound_on,
    output logic [1:0]  status
);

    typedef enum logic [24:0] {
        ST_CLEAR = 25'b1 << 0,
        ST_IDLE  = 25'b1 << 1,
        ST_MRD   = 25'b1 << 2,
        ST_PRD   = 25'b1 << 3,
        ST_F1    = 25'b1 << 4,
        ST_F2    = 25'b1 << 5,
        ST_F3    = 25'b1 << 6,
        ST_F4    = 25'b1 << 7,
        ST_F5    = 25'b1 << 8,
        ST_F6    = 25'b1 << 9,
        ST_EXEC  = 25'b1 << 10,
        ST_WVF   = 25'b1 << 11,
        ST_FBCLR = 25'b1 << 12,
        ST_ROW   = 25'b1 << 13,
        ST_ROWD  = 25'b1 << 14,
        ST_PIX   = 25'b1 << 15,
        ST_PIXD  = 25'b1 << 16,
        ST_DNEXT = 25'b1 << 17,
        ST_DVF   = 25'b1 << 18,
        ST_BCD   = 25'b1 << 19,
        ST_STRD  = 25'b1 << 20,
        ST_STWR  = 25'b1 << 21,
        ST_LDRD  = 25'b1 << 22,
        ST_LDWR  = 25'b1 << 23,
        ST_DONE  = 25'b1 << 24
    } state_t;

    localparam int AW = c8cpu_pkg::MEM_AW;
    localparam int SW = c8cpu_pkg::SP_W;
    localparam int PW = c8cpu_pkg::PIX_AW;
    localparam int VW = c8cpu_pkg::V_AW;

    state_t state_reg, state_next;

    logic [15:0] pc_reg, pc_next;
    logic [15:0] i_reg, i_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [7:0]  delay_reg, delay_next;
    logic [7:0]  sound_reg, sound_next;
    logic        sflag_reg, sflag_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] stack_reg [c8cpu_pkg::STACK_DEPTH];

    logic [11:0] addr_reg, addr_next;
    logic [15:0] know_reg, know_next;
    logic [15:0] kbef_reg, kbef_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [15:0] ins_reg, ins_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic [7:0]  v0_reg, v0_next;
    logic [3:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;
    logic [7:0]  bits_reg, bits_next;
    logic        coll_reg, coll_next;
    logic        clip_reg, clip_next;
    logic        vf_reg, vf_next;
    logic [1:0]  hund_reg, hund_next;
    logic [6:0]  rem_reg, rem_next;
    logic [3:0]  tens_reg, tens_next;
    logic [3:0]  ones_reg, ones_next;
    logic [7:0]  res_rd_reg, res_rd_next;
    logic        res_drawn_reg, res_drawn_next;
    logic [1:0]  res_stat_reg, res_stat_next;
    logic [7:0]  out_rd_reg, out_rd_next;
    logic [15:0] out_pc_reg, out_pc_next;
    logic        out_drawn_reg, out_drawn_next;
    logic        out_snd_reg, out_snd_next;
    logic [1:0]  out_stat_reg, out_stat_next;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic          fb_we;
    logic [PW-1:0] fb_addr;
    logic          fb_wdata, fb_rdata;
    logic          v_we;
    logic [VW-1:0] v_addr;
    logic [7:0]    v_wdata, v_rdata;
    logic          stk_we;

    c8cpu_pkg::alu_res_t alu_res;

    logic [3:0]    x_idx;
    logic [7:0]    nn;
    logic [11:0]   nnn;
    logic [SW-1:0] sp_dec;
    logic [SW-1:0] sp_inc;
    logic [8:0]    px;
    logic [8:0]    py;
    logic [PW-1:0] pix_addr;
    logic          pix_skip;
    logic [15:0]   key_rel;
    logic [3:0]    key_idx;
    logic [14:0]   tens_prod;
    logic [AW-1:0] i_off;

    c8cpu_ram #(.WIDTH(8), .DEPTH(c8cpu_pkg::MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    c8cpu_ram #(.WIDTH(1), .DEPTH(c8cpu_pkg::PIXEL_COUNT)) u_fb (
        .clk   (clk),
        .we    (fb_we),
        .addr  (fb_addr),
        .wdata (fb_wdata),
        .rdata (fb_rdata)
    );

    c8cpu_ram #(.WIDTH(8), .DEPTH(c8cpu_pkg::NUM_V)) u_vregs (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (v_wdata),
        .rdata (v_rdata)
    );

    c8cpu_alu u_alu (
        .op  (ins_reg[3:0]),
        .vx  (vx_reg),
        .vy  (vy_reg),
        .res (alu_res)
    );

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign read_data       = out_rd_reg;
    assign program_counter = out_pc_reg;
    assign screen_changed  = out_drawn_reg;
    assign sound_on        = out_snd_reg;
    assign status          = out_stat_reg;

    assign x_idx  = ins_reg[11:8];
    assign nn     = ins_reg[7:0];
    assign nnn    = ins_reg[11:0];
    assign sp_dec = (sp_reg == '0) ? SW'(c8cpu_pkg::STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sp_inc = (sp_reg == SW'(c8cpu_pkg::STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign px     = {1'b0, vx_reg} + {6'd0, col_reg};
    assign py     = {1'b0, vy_reg} + {5'd0, row_reg};
    assign pix_addr = {py[c8cpu_pkg::PY_W-1:0], px[c8cpu_pkg::PX_W-1:0]};
    assign pix_skip = (clip_reg && (px >= 9'(c8cpu_pkg::SCREEN_WIDTH)))
                      || !bits_reg[3'd7 - col_reg];
    assign key_rel   = kbef_reg & ~know_reg;
    // tens digit of rem as (rem * 205) >> 11, exact for rem below 100
    assign tens_prod = {8'd0, rem_reg} * 15'd205;
    assign i_off     = i_reg[AW-1:0] + AW'(cnt_reg[VW-1:0]);

    always_comb
    begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (key_rel[k])
            begin
                key_idx = 4'(k);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        delay_next     = delay_reg;
        sound_next     = sound_reg;
        sflag_next     = sflag_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        addr_next      = addr_reg;
        know_next      = know_reg;
        kbef_next      = kbef_reg;
        rnd_next       = rnd_reg;
        ins_next       = ins_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        v0_next        = v0_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        bits_next      = bits_reg;
        coll_next      = coll_reg;
        clip_next      = clip_reg;
        vf_next        = vf_reg;
        hund_next      = hund_reg;
        rem_next       = rem_reg;
        tens_next      = tens_reg;
        ones_next      = ones_reg;
        res_rd_next    = res_rd_reg;
        res_drawn_next = res_drawn_reg;
        res_stat_next  = res_stat_reg;
        out_rd_next    = out_rd_reg;
        out_pc_next    = out_pc_reg;
        out_drawn_next = out_drawn_reg;
        out_snd_next   = out_snd_reg;
        out_stat_next  = out_stat_reg;

        mem_we    = 1'b0;
        mem_addr  = address;
        mem_wdata = data;
        fb_we     = 1'b0;
        fb_addr   = address[PW-1:0];
        fb_wdata  = 1'b0;
        v_we      = 1'b0;
        v_addr    = '0;
        v_wdata   = 8'd0;
        stk_we    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = (cnt_reg < AW'(c8cpu_pkg::FONT_BYTES))
                            ? c8cpu_pkg::FONT[cnt_reg[6:0]] : 8'd0;
                fb_we     = (cnt_reg < AW'(c8cpu_pkg::PIXEL_COUNT));
                fb_addr   = cnt_reg[PW-1:0];
                v_we      = (cnt_reg < AW'(c8cpu_pkg::NUM_V));
                v_addr    = cnt_reg[VW-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == AW'(c8cpu_pkg::MEM_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next      = address;
                    know_next      = key_now;
                    kbef_next      = key_before;
                    rnd_next       = random_byte;
                    res_rd_next    = 8'd0;
                    res_drawn_next = 1'b0;
                    res_stat_next  = c8cpu_pkg::STAT_OK;
                    state_next     = ST_DONE;
                    unique case (opcode)
                        c8cpu_pkg::CMD_WRITE: mem_we = 1'b1;
                        c8cpu_pkg::CMD_READ:  state_next = ST_MRD;
                        c8cpu_pkg::CMD_PIXEL: state_next = ST_PRD;
                        c8cpu_pkg::CMD_EXEC:  state_next = ST_F1;
                        c8cpu_pkg::CMD_TICK:
                        begin
                            if (delay_reg != 8'd0)
                            begin
                                delay_next = delay_reg - 8'd1;
                            end
                            sflag_next = (sound_reg != 8'd0);
                            if (sound_reg != 8'd0)
                            begin
                                sound_next = sound_reg - 8'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MRD:
            begin
                res_rd_next = mem_rdata;
                state_next  = ST_DONE;
            end
            ST_PRD:
            begin
                res_rd_next = (addr_reg < 12'(c8cpu_pkg::PIXEL_COUNT))
                              ? {7'd0, fb_rdata} : 8'd0;
                state_next  = ST_DONE;
            end
            ST_F1:
            begin
                mem_addr   = pc_reg[AW-1:0];
                state_next = ST_F2;
            end
            ST_F2:
            begin
                mem_addr       = pc_reg[AW-1:0] + 1'b1;
                ins_next[15:8] = mem_rdata;
                state_next     = ST_F3;
            end
            ST_F3:
            begin
                ins_next[7:0] = mem_rdata;
                v_addr        = ins_reg[11:8];
                state_next    = ST_F4;
            end
            ST_F4:
            begin
                vx_next    = v_rdata;
                v_addr     = ins_reg[7:4];
                state_next = ST_F5;
            end
            ST_F5:
            begin
                vy_next    = v_rdata;
                v_addr     = '0;
                state_next = ST_F6;
            end
            ST_F6:
            begin
                v0_next    = v_rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                v_addr     = x_idx;
                pc_next    = pc_reg + 16'd2;
                unique case (ins_reg[15:12])
                    4'h0:
                    begin
                        if (ins_reg == 16'h00E0)
                        begin
                            res_drawn_next = 1'b1;
                            cnt_next       = '0;
                            state_next     = ST_FBCLR;
                        end
                        else if (ins_reg == 16'h00EE)
                        begin
                            sp_next = sp_dec;
                            pc_next = stack_reg[sp_dec] + 16'd2;
                        end
                    end
                    4'h1: pc_next = {4'd0, nnn};
                    4'h2:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = {4'd0, nnn};
                    end
                    4'h3: if (vx_reg == nn) pc_next = pc_reg + 16'd4;
                    4'h4: if (vx_reg != nn) pc_next = pc_reg + 16'd4;
                    4'h5: if (vx_reg == vy_reg) pc_next = pc_reg + 16'd4;
                    4'h6:
                    begin
                        v_we    = 1'b1;
                        v_wdata = nn;
                    end
                    4'h7:
                    begin
                        v_we    = 1'b1;
                        v_wdata = vx_reg + nn;
                    end
                    4'h8:
                    begin
                        if (!alu_res.legal)
                        begin
                            pc_next       = pc_reg;
                            res_stat_next = c8cpu_pkg::STAT_UNKNOWN;
                        end
                        else
                        begin
                            v_we    = 1'b1;
                            v_wdata = alu_res.result;
                            vf_next = alu_res.flag;
                            if (alu_res.vf_we)
                            begin
                                state_next = ST_WVF;
                            end
                        end
                    end
                    4'h9: if (vx_reg != vy_reg) pc_next = pc_reg + 16'd4;
                    4'hA: i_next = {4'd0, nnn};
                    4'hB: pc_next = {4'd0, nnn} + {8'd0, v0_reg};
                    4'hC:
                    begin
                        v_we    = 1'b1;
                        v_wdata = rnd_reg & nn;
                    end
                    4'hD:
                    begin
                        clip_next      = (vx_reg < 8'(c8cpu_pkg::SCREEN_WIDTH))
                                         && (vy_reg < 8'(c8cpu_pkg::SCREEN_HEIGHT));
                        coll_next      = 1'b0;
                        row_next       = 4'd0;
                        res_drawn_next = 1'b1;
                        state_next     = (ins_reg[3:0] == 4'd0) ? ST_DVF : ST_ROW;
                    end
                    4'hE:
                    begin
                        if (nn == 8'h9E)
                        begin
                            if (know_reg[vx_reg[3:0]]) pc_next = pc_reg + 16'd4;
                        end
                        else if (nn == 8'hA1)
                        begin
                            if (!know_reg[vx_reg[3:0]]) pc_next = pc_reg + 16'd4;
                        end
                        else
                        begin
                            pc_next       = pc_reg;
                            res_stat_next = c8cpu_pkg::STAT_UNKNOWN;
                        end
                    end
                    default:
                    begin
                        unique case (nn)
                            8'h07:
                            begin
                                v_we    = 1'b1;
                                v_wdata = delay_reg;
                            end
                            8'h0A:
                            begin
                                if (key_rel != 16'd0)
                                begin
                                    v_we    = 1'b1;
                                    v_wdata = {4'd0, key_idx};
                                end
                                else
                                begin
                                    pc_next       = pc_reg;
                                    res_stat_next = c8cpu_pkg::STAT_WAITKEY;
                                end
                            end
                            8'h15: delay_next = vx_reg;
                            8'h18: sound_next = vx_reg;
                            8'h1E: i_next = i_reg + {8'd0, vx_reg};
                            8'h29: i_next = {10'd0, vx_reg[3:0], 2'b00} + {12'd0, vx_reg[3:0]};
                            8'h33:
                            begin
                                if (vx_reg >= 8'd200)
                                begin
                                    hund_next = 2'd2;
                                    rem_next  = 7'(vx_reg - 8'd200);
                                end
                                else if (vx_reg >= 8'd100)
                                begin
                                    hund_next = 2'd1;
                                    rem_next  = 7'(vx_reg - 8'd100);
                                end
                                else
                                begin
                                    hund_next = 2'd0;
                                    rem_next  = vx_reg[6:0];
                                end
                                cnt_next   = '0;
                                state_next = ST_BCD;
                            end
                            8'h55:
                            begin
                                cnt_next   = '0;
                                state_next = ST_STRD;
                            end
                            8'h65:
                            begin
                                cnt_next   = '0;
                                state_next = ST_LDRD;
                            end
                            default:
                            begin
                                pc_next       = pc_reg;
                                res_stat_next = c8cpu_pkg::STAT_UNKNOWN;
                            end
                        endcase
                    end
                endcase
            end
            ST_WVF:
            begin
                v_we       = 1'b1;
                v_addr     = VW'(c8cpu_pkg::NUM_V - 1);
                v_wdata    = {7'd0, vf_reg};
                state_next = ST_DONE;
            end
            ST_FBCLR:
            begin
                fb_we    = 1'b1;
                fb_addr  = cnt_reg[PW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[PW-1:0] == PW'(c8cpu_pkg::PIXEL_COUNT - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ROW:
            begin
                mem_addr   = i_reg[AW-1:0] + AW'(row_reg);
                state_next = ST_ROWD;
            end
            ST_ROWD:
            begin
                bits_next = mem_rdata;
                col_next  = 3'd0;
                if (clip_reg && (py >= 9'(c8cpu_pkg::SCREEN_HEIGHT)))
                begin
                    state_next = ST_DNEXT;
                end
                else
                begin
                    state_next = ST_PIX;
                end
            end
            ST_PIX:
            begin
                fb_addr = pix_addr;
                if (pix_skip)
                begin
                    col_next = col_reg + 3'd1;
                    if (col_reg == 3'd7)
                    begin
                        state_next = ST_DNEXT;
                    end
                end
                else
                begin
                    state_next = ST_PIXD;
                end
            end
            ST_PIXD:
            begin
                fb_we     = 1'b1;
                fb_addr   = pix_addr;
                fb_wdata  = ~fb_rdata;
                coll_next = coll_reg | fb_rdata;
                col_next  = col_reg + 3'd1;
                state_next = (col_reg == 3'd7) ? ST_DNEXT : ST_PIX;
            end
            ST_DNEXT:
            begin
                row_next = row_reg + 4'd1;
                state_next = ((row_reg + 4'd1) == ins_reg[3:0]) ? ST_DVF : ST_ROW;
            end
            ST_DVF:
            begin
                v_we       = 1'b1;
                v_addr     = VW'(c8cpu_pkg::NUM_V - 1);
                v_wdata    = {7'd0, coll_reg};
                state_next = ST_DONE;
            end
            ST_BCD:
            begin
                mem_we   = 1'b1;
                mem_addr = i_off;
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mem_wdata = {6'd0, hund_reg};
                        tens_next = tens_prod[14:11];
                    end
                    2'd1:
                    begin
                        mem_wdata = {4'd0, tens_reg};
                        ones_next = 4'(rem_reg - {tens_reg, 3'b000} - {2'b00, tens_reg, 1'b0});
                    end
                    default:
                    begin
                        mem_wdata  = {4'd0, ones_reg};
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_STRD:
            begin
                v_addr     = cnt_reg[VW-1:0];
                state_next = ST_STWR;
            end
            ST_STWR:
            begin
                mem_we    = 1'b1;
                mem_addr  = i_off;
                mem_wdata = v_rdata;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[VW-1:0] == x_idx)
                begin
                    i_next     = i_reg + {12'd0, x_idx} + 16'd1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_STRD;
                end
            end
            ST_LDRD:
            begin
                mem_addr   = i_off;
                state_next = ST_LDWR;
            end
            ST_LDWR:
            begin
                v_we     = 1'b1;
                v_addr   = cnt_reg[VW-1:0];
                v_wdata  = mem_rdata;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[VW-1:0] == x_idx)
                begin
                    i_next     = i_reg + {12'd0, x_idx} + 16'd1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LDRD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = res_rd_reg;
                    out_pc_next    = pc_reg;
                    out_drawn_next = res_drawn_reg;
                    out_snd_next   = sflag_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pc_reg        <= c8cpu_pkg::PC_START;
            i_reg         <= 16'd0;
            sp_reg        <= '0;
            delay_reg     <= 8'd0;
            sound_reg     <= 8'd0;
            sflag_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < c8cpu_pkg::STACK_DEPTH; k++)
            begin
                stack_reg[k] <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            sflag_reg     <= sflag_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (stk_we)
            begin
                stack_reg[sp_reg] <= pc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        know_reg      <= know_next;
        kbef_reg      <= kbef_next;
        rnd_reg       <= rnd_next;
        ins_reg       <= ins_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        v0_reg        <= v0_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        bits_reg      <= bits_next;
        coll_reg      <= coll_next;
        clip_reg      <= clip_next;
        vf_reg        <= vf_next;
        hund_reg      <= hund_next;
        rem_reg       <= rem_next;
        tens_reg      <= tens_next;
        ones_reg      <= ones_next;
        res_rd_reg    <= res_rd_next;
        res_drawn_reg <= res_drawn_next;
        res_stat_reg  <= res_stat_next;
        out_rd_reg    <= out_rd_next;
        out_pc_reg    <= out_pc_next;
        out_drawn_reg <= out_drawn_next;
        out_snd_reg   <= out_snd_next;
        out_stat_reg  <= out_stat_next;
    end

endmodule

[rtl/core/c8cpu_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module c8cpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/c8cpu_alu.sv]
// Register-to-register ALU for the 8XYn instruction group.
// Depends on c8cpu_pkg.
module c8cpu_alu (
    input  logic [3:0]           op,
    input  logic [7:0]           vx,
    input  logic [7:0]           vy,
    output c8cpu_pkg::alu_res_t  res
);

    logic [8:0] sum;
    logic [8:0] dxy;
    logic [8:0] dyx;

    assign sum = {1'b0, vx} + {1'b0, vy};
    assign dxy = {1'b0, vx} - {1'b0, vy};
    assign dyx = {1'b0, vy} - {1'b0, vx};

    always_comb
    begin
        res = '{result: 8'd0, flag: 1'b0, vf_we: 1'b1, legal: 1'b1};
        unique case (op)
            c8cpu_pkg::ALU_MOV:
            begin
                res.result = vy;
                res.vf_we  = 1'b0;
            end
            c8cpu_pkg::ALU_OR:  res.result = vx | vy;
            c8cpu_pkg::ALU_AND: res.result = vx & vy;
            c8cpu_pkg::ALU_XOR: res.result = vx ^ vy;
            c8cpu_pkg::ALU_ADD:
            begin
                res.result = sum[7:0];
                res.flag   = sum[8];
            end
            c8cpu_pkg::ALU_SUB:
            begin
                res.result = dxy[7:0];
                res.flag   = ~dxy[8];
            end
            c8cpu_pkg::ALU_SHR:
            begin
                res.result = {1'b0, vy[7:1]};
                res.flag   = vy[0];
            end
            c8cpu_pkg::ALU_RSB:
            begin
                res.result = dyx[7:0];
                res.flag   = ~dyx[8];
            end
            c8cpu_pkg::ALU_SHL:
            begin
                res.result = {vy[6:0], 1'b0};
                res.flag   = vy[7];
            end
            default:
            begin
                res.legal = 1'b0;
                res.vf_we = 1'b0;
            end
        endcase
    end

endmodule
